// ===== rtl/zbsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package zbsf_pkg;

	localparam int COL_W   = 6;
	localparam int ROW_W   = 5;
	localparam int X_W     = 8;
	localparam int DEPTH_W = 8;
	localparam int GLYPH_W = 8;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_LIMIT      = 1'b1;

	localparam logic [CFG_DATA_W-1:0] LEFT_LIMIT_RESET = 6'd2;
	localparam logic [DEPTH_W-1:0]    DEPTH_FARTHEST   = 8'hFF;

	// Stream payload widths; the tdata widths are whole bytes
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 24;

	typedef logic [COL_W-1:0] col_t;

	// Clamped span: columns hi down to lo are examined
	typedef struct packed {
		logic empty;
		col_t hi;
		col_t lo;
	} span_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/zbsf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module zbsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1280
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/zbsf_span.sv =====
`timescale 1ns / 1ps
`default_nettype none

module zbsf_span #(
	parameter int SCREEN_COLUMNS = 40
) (
	input  wire                                  sat_mode,
	input  wire  [zbsf_pkg::CFG_DATA_W-1:0]      left_limit,
	input  wire  signed [zbsf_pkg::X_W-1:0]      x_first,
	input  wire  signed [zbsf_pkg::X_W-1:0]      x_second,
	input  wire                                  first_is_right,
	input  wire                                  first_saturated,
	input  wire                                  second_saturated,
	output zbsf_pkg::span_t                      span
);

	localparam logic signed [8:0] COL_MAX = 9'(SCREEN_COLUMNS - 1);

	logic signed [8:0] lx, rx, ll, start_raw, stop_raw, start_c, stop_c;
	logic              lsat, rsat;

	always_comb begin
		ll = signed'({3'b000, left_limit});
		if (first_is_right) begin
			lx   = 9'(x_second);
			lsat = second_saturated;
			rx   = 9'(x_first);
			rsat = first_saturated;
		end else begin
			lx   = 9'(x_first);
			lsat = first_saturated;
			rx   = 9'(x_second);
			rsat = second_saturated;
		end

		if (sat_mode) begin
			start_raw = lsat ? ll : lx;
			stop_raw  = rsat ? COL_MAX : rx;
		end else begin
			start_raw = (lx > ll) ? lx : ll;
			stop_raw  = (rx < COL_MAX) ? rx : COL_MAX;
		end

		// safety clamp onto the screen
		start_c = (start_raw < 9'sd0) ? 9'sd0 : start_raw;
		stop_c  = (stop_raw > COL_MAX) ? COL_MAX : stop_raw;

		span.empty = (stop_c <= start_c);
		span.hi    = stop_c[zbsf_pkg::COL_W-1:0];
		span.lo    = start_c[zbsf_pkg::COL_W-1:0] + 6'd1;
	end

endmodule

`default_nettype wire

// ===== rtl/zbuffered_span_fill.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Signals                                  Contents
// s_*        in         s_tvalid s_tready s_tdata s_tuser        one span request
// m_*        out        m_tvalid m_tready m_tdata m_tuser m_tlast one examined column
// cfg_*      in         cfg_valid cfg_ready cfg_index cfg_data   register write
//
// A span is first accepted and clamped, then each column gets a depth read and a
// compare-and-write, both on the single depth memory port pair. Empty spans and rows
// off screen are dropped in the accept step.
// After reset the depth store is swept to farthest, one entry a cycle, over all
// SCREEN_ROWS*SCREEN_COLUMNS entries (1280 by default); no item is taken meanwhile.
// A full output register with m_tready low stalls the column loop in its compare step.
// Configuration writes are always taken.

module zbuffered_span_fill #(
	parameter int SCREEN_COLUMNS = 40,
	parameter int SCREEN_ROWS    = 32
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// row[4:0], x_first[12:5], x_second[20:13], depth[28:21], glyph[36:29], zero fill
	input  wire  [zbsf_pkg::S_TDATA_W-1:0]     s_tdata,
	// first_is_right[0], first_saturated[1], second_saturated[2]
	input  wire  [zbsf_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// out_row[4:0], out_column[10:5], out_glyph[18:11], zero fill
	output logic [zbsf_pkg::M_TDATA_W-1:0]     m_tdata,
	// written[0]
	output logic                               m_tuser,
	output logic                               m_tlast,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [zbsf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire  [zbsf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CELLS  = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
	localparam logic [8:0]        ROW_CNT   = 9'(SCREEN_ROWS);

	zbsf_pkg::state_t state_q, state_d;

	// configuration
	logic                            sat_mode_q;
	logic [zbsf_pkg::CFG_DATA_W-1:0] left_limit_q;

	// span context
	logic [zbsf_pkg::ROW_W-1:0]   row_q;
	logic [ADDR_W-1:0]            base_q;
	zbsf_pkg::col_t               col_q, last_col_q;
	logic [zbsf_pkg::DEPTH_W-1:0] depth_q;
	logic [zbsf_pkg::GLYPH_W-1:0] glyph_q;
	logic [ADDR_W-1:0]            clr_q;

	// output register
	logic                         m_valid_q, m_written_q, m_last_q;
	logic [zbsf_pkg::ROW_W-1:0]   m_row_q;
	zbsf_pkg::col_t               m_col_q;
	logic [zbsf_pkg::GLYPH_W-1:0] m_glyph_q;

	// unpacked input fields
	logic [zbsf_pkg::ROW_W-1:0]          in_row;
	logic signed [zbsf_pkg::X_W-1:0]     in_x_first, in_x_second;
	logic [zbsf_pkg::DEPTH_W-1:0]        in_depth;
	logic [zbsf_pkg::GLYPH_W-1:0]        in_glyph;
	zbsf_pkg::span_t                     span;
	logic                                row_ok, take;
	logic [ADDR_W-1:0]                   base_d, cell_addr;

	// memory port
	logic                         ram_we, ram_re;
	logic [ADDR_W-1:0]            ram_waddr;
	logic [zbsf_pkg::DEPTH_W-1:0] ram_wdata, ram_rdata;

	logic out_free, load_out, pass;

	assign in_row      = s_tdata[4:0];
	assign in_x_first  = signed'(s_tdata[12:5]);
	assign in_x_second = signed'(s_tdata[20:13]);
	assign in_depth    = s_tdata[28:21];
	assign in_glyph    = s_tdata[36:29];

	zbsf_span #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS)
	) u_span (
		.sat_mode        (sat_mode_q),
		.left_limit      (left_limit_q),
		.x_first         (in_x_first),
		.x_second        (in_x_second),
		.first_is_right  (s_tuser[0]),
		.first_saturated (s_tuser[1]),
		.second_saturated(s_tuser[2]),
		.span            (span)
	);

	assign row_ok    = (9'(in_row) < ROW_CNT);
	assign base_d    = ADDR_W'(32'(in_row) * 32'(SCREEN_COLUMNS));
	assign cell_addr = base_q + ADDR_W'(col_q);
	assign out_free  = !m_valid_q || m_tready;
	assign pass      = (depth_q < ram_rdata);

	zbsf_ram #(
		.WIDTH(zbsf_pkg::DEPTH_W),
		.DEPTH(CELLS)
	) u_depth_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(cell_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= zbsf_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state and control
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		take      = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = cell_addr;
		ram_wdata = depth_q;
		load_out  = 1'b0;
		unique case (state_q)
			zbsf_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = zbsf_pkg::DEPTH_FARTHEST;
				if (clr_q == LAST_CELL) begin
					state_d = zbsf_pkg::ST_IDLE;
				end
			end
			zbsf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				take     = s_tvalid;
				// drop empty spans and rows off screen here
				if (s_tvalid && row_ok && !span.empty) begin
					state_d = zbsf_pkg::ST_READ;
				end
			end
			zbsf_pkg::ST_READ: begin
				ram_re  = 1'b1;
				state_d = zbsf_pkg::ST_CHECK;
			end
			zbsf_pkg::ST_CHECK: begin
				if (out_free) begin
					load_out = 1'b1;
					ram_we   = pass;
					state_d  = (col_q == last_col_q) ? zbsf_pkg::ST_IDLE : zbsf_pkg::ST_READ;
				end
			end
			default: state_d = zbsf_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == zbsf_pkg::ST_CLEAR) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// hold the span context, step the column down after each compare
	always_ff @(posedge clk) begin
		if (take) begin
			row_q      <= in_row;
			base_q     <= base_d;
			col_q      <= span.hi;
			last_col_q <= span.lo;
			depth_q    <= in_depth;
			glyph_q    <= in_glyph;
		end else if (load_out) begin
			col_q <= col_q - 6'd1;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_mode_q   <= 1'b0;
			left_limit_q <= zbsf_pkg::LEFT_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				zbsf_pkg::REG_SATURATION_MODE: sat_mode_q   <= cfg_data[0];
				zbsf_pkg::REG_LEFT_LIMIT:      left_limit_q <= cfg_data;
				default:                       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_row_q     <= row_q;
			m_col_q     <= col_q;
			m_glyph_q   <= pass ? glyph_q : '0;
			m_written_q <= pass;
			m_last_q    <= (col_q == last_col_q);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b00000, m_glyph_q, m_col_q, m_row_q};
	assign m_tuser  = m_written_q;
	assign m_tlast  = m_last_q;

	// the final column of a span returns the sequencer to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == zbsf_pkg::ST_CHECK && load_out && col_q == last_col_q)
		|=> (state_q == zbsf_pkg::ST_IDLE))
		else $error("span did not end on its last column");

	// the column walk stays between the span ends and on screen
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == zbsf_pkg::ST_READ)
		|-> (col_q >= last_col_q && 32'(col_q) < SCREEN_COLUMNS))
		else $error("column out of span");

	// a stalled result holds the compare step
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == zbsf_pkg::ST_CHECK && m_valid_q && !m_tready)
		|=> (state_q == zbsf_pkg::ST_CHECK))
		else $error("compare advanced over a stalled result");

	// the clearing sweep ends after the last cell
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == zbsf_pkg::ST_CLEAR && clr_q == LAST_CELL)
		|=> (state_q == zbsf_pkg::ST_IDLE && !m_valid_q))
		else $error("clear sweep did not finish");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import zbsf_pkg::*;

	localparam int COLS = 40;
	localparam int ROWS = 32;
	localparam int STALL_LIMIT = 5000;   // covers the clear sweep and the long hold
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [X_W-1:0]     x_first;
		logic [X_W-1:0]     x_second;
		logic               first_is_right;
		logic               first_sat;
		logic               second_sat;
		logic [DEPTH_W-1:0] depth;
		logic [GLYPH_W-1:0] glyph;
	} span_req_t;

	typedef struct packed {
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   column;
		logic [GLYPH_W-1:0] glyph;
		logic               written;
		logic               is_last;
	} column_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state: depth store and registers as the block should hold them
	logic [DEPTH_W-1:0] depth_model [ROWS*COLS];
	logic saturation_on = 1'b0;
	logic [COL_W-1:0] left_limit = LEFT_LIMIT_RESET;

	span_req_t span_q[$];
	span_req_t cur_span;
	column_write_t column_writes_due[$];
	column_write_t want;
	int spans_queued = 0;
	int spans_taken = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int errors = 0;

	always #2 clk = ~clk;

	zbuffered_span_fill #(
		.SCREEN_COLUMNS(COLS),
		.SCREEN_ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clamp the span, then depth-test columns from the right end down to start+1
	function automatic void predict_span_columns(input span_req_t r);
		int lx, rx, lo, hi, ll, idx;
		logic lsat, rsat;
		column_write_t w;
		// rows off screen produce nothing
		if (int'(r.row) >= ROWS)
			return;
		ll = int'(left_limit);
		if (r.first_is_right) begin
			lx = $signed(r.x_second);
			lsat = r.second_sat;
			rx = $signed(r.x_first);
			rsat = r.first_sat;
		end else begin
			lx = $signed(r.x_first);
			lsat = r.first_sat;
			rx = $signed(r.x_second);
			rsat = r.second_sat;
		end
		if (saturation_on) begin
			lo = lsat ? ll : lx;
			hi = rsat ? COLS - 1 : rx;
		end else begin
			lo = (lx > ll) ? lx : ll;
			hi = (rx < COLS - 1) ? rx : COLS - 1;
		end
		if (lo < 0)
			lo = 0;
		if (hi > COLS - 1)
			hi = COLS - 1;
		for (int c = hi; c > lo; c--) begin
			idx = int'(r.row) * COLS + c;
			w.row = r.row;
			w.column = COL_W'(c);
			w.written = r.depth < depth_model[idx];
			w.glyph = w.written ? r.glyph : '0;
			w.is_last = (c == lo + 1);
			if (w.written)
				depth_model[idx] = r.depth;
			column_writes_due.push_back(w);
		end
	endfunction

	function automatic span_req_t mk_span(input int row, xf, xs, input bit fr, fs, ss,
			input int d, g);
		span_req_t r;
		r.row = ROW_W'(row);
		r.x_first = X_W'(xf);
		r.x_second = X_W'(xs);
		r.first_is_right = fr;
		r.first_sat = fs;
		r.second_sat = ss;
		r.depth = DEPTH_W'(d);
		r.glyph = GLYPH_W'(g);
		return r;
	endfunction

	// Mostly on-screen edges, sometimes anywhere in the signed range
	function automatic logic [X_W-1:0] rand_edge();
		if ($urandom_range(9) < 7)
			return X_W'(int'($urandom_range(50)) - 6);
		return X_W'($urandom());
	endfunction

	function automatic span_req_t rand_span();
		span_req_t r;
		r.row = ROW_W'($urandom_range(ROWS - 1));
		r.x_first = rand_edge();
		r.x_second = rand_edge();
		r.first_is_right = 1'($urandom_range(1));
		r.first_sat = 1'($urandom_range(1));
		r.second_sat = 1'($urandom_range(1));
		// keep some faces near so writes still happen once the store fills up
		r.depth = ($urandom_range(1) != 0) ? DEPTH_W'($urandom()) : DEPTH_W'($urandom_range(31));
		r.glyph = GLYPH_W'($urandom());
		return r;
	endfunction

	task automatic push_span(input span_req_t r);
		span_q.push_back(r);
		spans_queued++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == REG_SATURATION_MODE)
			saturation_on = val[0];
		else
			left_limit = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_phase(input logic sat, input logic [COL_W-1:0] ll, input int s_idle,
			input int r_stall);
		write_reg(REG_SATURATION_MODE, CFG_DATA_W'(sat));
		write_reg(REG_LEFT_LIMIT, ll);
		send_idle_pct = s_idle;
		recv_stall_pct = r_stall;
	endtask

	// Wait until every span is taken and every column result is out, then let
	// an empty span still in flight settle
	task automatic drain();
		while (spans_taken != spans_queued || column_writes_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Driver: present spans from the queue, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_span_columns(cur_span);
				spans_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (span_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_span = span_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {3'b000, cur_span.glyph, cur_span.depth, cur_span.x_second,
						cur_span.x_first, cur_span.row};
					s_tuser <= {cur_span.second_sat, cur_span.first_sat,
						cur_span.first_is_right};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// One long receiver hold, counted down here so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_request && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: check each column result against the oldest one due
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (column_writes_due.size() == 0) begin
					$error("column result with none due: tdata %h tuser %b tlast %b",
						m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					want = column_writes_due.pop_front();
					if (m_tdata[4:0] !== want.row) begin
						$error("out_row: expected %0d, got %0d", want.row, m_tdata[4:0]);
						errors++;
					end
					if (m_tdata[10:5] !== want.column) begin
						$error("out_column: expected %0d, got %0d", want.column, m_tdata[10:5]);
						errors++;
					end
					if (m_tdata[18:11] !== want.glyph) begin
						$error("out_glyph: expected %0d, got %0d", want.glyph, m_tdata[18:11]);
						errors++;
					end
					if (m_tuser !== want.written) begin
						$error("written: expected %0d, got %0d", want.written, m_tuser);
						errors++;
					end
					if (m_tlast !== want.is_last) begin
						$error("last: expected %0d, got %0d", want.is_last, m_tlast);
						errors++;
					end
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		foreach (depth_model[i])
			depth_model[i] = DEPTH_FARTHEST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Clamping mode, no idling: field extremes and edge cases
		set_phase(1'b0, 6'd2, 0, 0);
		push_span(mk_span(0, 0, 39, 0, 0, 0, 100, 8'h41));
		push_span(mk_span(0, 0, 39, 0, 0, 0, 100, 8'h42));     // equal depth: no write
		push_span(mk_span(0, 39, 0, 1, 0, 0, 50, 8'h43));      // nearer, right end first
		push_span(mk_span(31, -128, 127, 0, 1, 1, 0, 8'hFF));  // both ends clamped
		push_span(mk_span(31, 127, -128, 1, 0, 0, 255, 8'h80));
		push_span(mk_span(5, 10, 10, 0, 0, 0, 7, 8'h01));      // empty span
		push_span(mk_span(5, 10, 11, 0, 0, 0, 7, 8'h02));      // single column
		push_span(mk_span(6, 20, 5, 0, 0, 0, 7, 8'h03));       // left end past right end
		push_span(mk_span(7, -1, 3, 0, 0, 0, 9, 8'h04));       // left end below limit
		push_span(mk_span(17, 8'h55, 8'hAA, 1, 0, 0, 8'hAA, 8'h55));
		push_span(mk_span(10, 3, 40, 0, 1, 0, 8'h55, 8'hAA));
		repeat (25) push_span(rand_span());
		drain();

		// Saturation mode, sender idling
		set_phase(1'b1, 6'd5, 48, 0);
		push_span(mk_span(1, 20, 20, 0, 1, 1, 3, 8'h10));      // both ends snap
		push_span(mk_span(2, 100, 12, 0, 1, 0, 3, 8'h11));     // left snaps, right as given
		push_span(mk_span(3, 0, -20, 1, 1, 0, 3, 8'h12));      // right snaps, left clamped to 0
		push_span(mk_span(4, -5, 60, 0, 0, 0, 3, 8'h13));      // column safety clamp both ends
		push_span(mk_span(8, 30, 10, 0, 0, 0, 3, 8'h14));      // empty
		push_span(mk_span(9, -128, 127, 1, 1, 1, 0, 8'hFE));
		repeat (45) push_span(rand_span());
		drain();

		set_phase(1'b0, 6'd63, 0, 48);
		repeat (20) push_span(rand_span());
		drain();

		set_phase(1'b1, 6'd63, 25, 25);
		repeat (20) push_span(rand_span());
		drain();

		// Long receiver hold while spans keep coming
		set_phase(1'b0, 6'd0, 0, 48);
		hold_request = 1'b1;
		repeat (50) push_span(rand_span());
		drain();

		set_phase(1'b1, COL_W'($urandom_range(63)), 25, 25);
		repeat (33) push_span(rand_span());
		drain();

		repeat (100) @(posedge clk);
		if (errors == 0 && column_writes_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
